FILE: design/fpss_pkg.sv
// Shared request codes and the pair tag type for the fragment profile set similarity core.
package fpss_pkg;

  localparam logic [1:0] REQ_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] REQ_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] REQ_COMPUTE    = 2'd2;
  localparam logic [1:0] REQ_IGNORED    = 2'd3;

  // Control that travels with one left/right pair down the scoring pipeline.
  typedef struct packed {
    logic       valid;
    logic       last_col;
    logic       last_row;
    logic [1:0] flag_hits;
    logic [2:0] zero;
  } pair_tag_t;

endpackage

FILE: design/fpss_div_cell.sv
// One cell of the scoring chain: one quotient bit for each of three count ratios.
module fpss_div_cell import fpss_pkg::*; #(
  parameter int QW = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pair_tag_t            tag_in,
  input  logic [2:0][8:0]      t_in,
  input  logic [2:0][7:0]      hi_in,
  input  logic [2:0][QW-1:0]   q_in,
  input  logic [QW-1:0]        hyd_in,
  output pair_tag_t            tag_out,
  output logic [2:0][8:0]      t_out,
  output logic [2:0][7:0]      hi_out,
  output logic [2:0][QW-1:0]   q_out,
  output logic [QW-1:0]        hyd_out
);

  logic [2:0]      ge;
  logic [2:0][7:0] rem;
  logic [2:0][8:0] diff;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ge[k]   = t_in[k] >= {1'b0, hi_in[k]};
      diff[k] = t_in[k] - {1'b0, hi_in[k]};
      rem[k]  = ge[k] ? diff[k][7:0] : t_in[k][7:0];
    end
  end

  // Only the valid bit is reset; the data fields simply follow it.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else begin
      tag_out.valid <= tag_in.valid;
    end
    tag_out.last_col  <= tag_in.last_col;
    tag_out.last_row  <= tag_in.last_row;
    tag_out.flag_hits <= tag_in.flag_hits;
    tag_out.zero      <= tag_in.zero;
    hyd_out           <= hyd_in;
    for (int k = 0; k < 3; k++) begin
      t_out[k]  <= {rem[k], 1'b0};
      hi_out[k] <= hi_in[k];
      q_out[k]  <= {q_in[k][QW-2:0], ge[k]};
    end
  end

endmodule

FILE: design/fpss_div_chain.sv
// Row of division cells that turns min/max count pairs into fixed point ratios.
module fpss_div_chain import fpss_pkg::*; #(
  parameter int QW = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pair_tag_t            tag_in,
  input  logic [2:0][7:0]      lo_in,
  input  logic [2:0][7:0]      hi_in,
  input  logic [QW-1:0]        hyd_in,
  output pair_tag_t            tag_out,
  output logic [2:0][QW-1:0]   q_out,
  output logic [QW-1:0]        hyd_out
);

  pair_tag_t            tag_w [0:QW];
  logic [2:0][8:0]      t_w   [0:QW];
  logic [2:0][7:0]      hi_w  [0:QW];
  logic [2:0][QW-1:0]   q_w   [0:QW];
  logic [QW-1:0]        hyd_w [0:QW];

  assign tag_w[0] = tag_in;
  assign hi_w[0]  = hi_in;
  assign hyd_w[0] = hyd_in;
  assign t_w[0]   = {{1'b0, lo_in[2]}, {1'b0, lo_in[1]}, {1'b0, lo_in[0]}};
  assign q_w[0]   = '0;

  for (genvar c = 0; c < QW; c++) begin : g_cell
    fpss_div_cell #(.QW(QW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tag_in (tag_w[c]),
      .t_in   (t_w[c]),
      .hi_in  (hi_w[c]),
      .q_in   (q_w[c]),
      .hyd_in (hyd_w[c]),
      .tag_out(tag_w[c+1]),
      .t_out  (t_w[c+1]),
      .hi_out (hi_w[c+1]),
      .q_out  (q_w[c+1]),
      .hyd_out(hyd_w[c+1])
    );
  end

  assign tag_out = tag_w[QW];
  assign q_out   = q_w[QW];
  assign hyd_out = hyd_w[QW];

endmodule

FILE: design/fragment_profile_set_similarity_core.sv
// Top level of the fragment profile set similarity core: profile stores, sequencer and scoring.
//
// Input channel (in_valid / in_stall) carries one request per transaction. A load-left or
// load-right transaction writes one profile into the matching store; a load into a full
// store is dropped and remembered in the overflow flag. Request code 3 is taken and
// ignored. A compute transaction snapshots both set sizes, empties both sets and clears
// the overflow flag, then produces exactly one output transaction (similarity,
// overflow_seen) on the out_valid / out_stall channel.
// A compute walks every pair twice, once per direction. Each direction issues one pair
// per cycle into a chain of FRAC_BITS+1 division cells, drains the chain, then divides
// the sum of per-profile bests by the set size one bit per cycle. With an empty set
// the result is ready the next cycle. While a compute runs, in_stall is high. A result
// waiting on a stalled receiver holds its value; loads are still taken meanwhile, but a
// new compute waits until the result has gone. Synchronous reset empties both sets and
// drops any pending result.
module fragment_profile_set_similarity_core import fpss_pkg::*; #(
  parameter int MAX_PROFILES = 64,
  parameter int FRAC_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  frag_volume,
  input  logic [7:0]  donor_count,
  input  logic [7:0]  acceptor_count,
  input  logic        has_ring,
  input  logic        is_aromatic,
  input  logic        has_amide,
  input  logic [16:0] hydro_frac,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] similarity,
  output logic        overflow_seen
);

  localparam int QW   = FRAC_BITS + 1;
  localparam int AW   = (MAX_PROFILES > 1) ? $clog2(MAX_PROFILES) : 1;
  localparam int CW   = $clog2(MAX_PROFILES + 1);
  localparam int PW   = QW + 27;
  localparam int SN   = FRAC_BITS + 3;
  localparam int K7   = SN + 3;
  localparam int MW   = K7 - 2;
  localparam logic [63:0] DIV7_M64 = ((64'd1 << K7) + 64'd6) / 64'd7;
  localparam logic [MW-1:0] DIV7_M = DIV7_M64[MW-1:0];
  localparam int SUMW = QW + CW;
  localparam int DCW  = $clog2(SUMW + 1);
  localparam int UP   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int DOWN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int HT   = 17 + UP;
  localparam int OT   = QW + DOWN;
  localparam logic [QW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CW-1:0] MAXC = CW'(MAX_PROFILES);

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_DIV} state_t;

  state_t          state;
  logic            dir;
  logic [AW-1:0]   row_i;
  logic [AW-1:0]   col_j;
  logic [CW-1:0]   left_cnt;
  logic [CW-1:0]   right_cnt;
  logic [CW-1:0]   na;
  logic [CW-1:0]   nb;
  logic            ovf;
  logic [QW-1:0]   fw;
  logic [CW-1:0]   div_rem;
  logic [SUMW-1:0] div_quo;
  logic [DCW-1:0]  div_cnt;
  logic            clr_acc;

  // Profile stores.
  logic [PW-1:0] left_mem  [MAX_PROFILES];
  logic [PW-1:0] right_mem [MAX_PROFILES];
  logic [PW-1:0] left_rd;
  logic [PW-1:0] right_rd;

  logic            in_acc;
  logic            we_left;
  logic            we_right;
  logic [16:0]     h_sat;
  logic [HT-1:0]   h_tmp;
  logic [PW-1:0]   wr_prof;

  assign in_stall = (state != ST_IDLE) || ((req_type == REQ_COMPUTE) && out_valid);
  assign in_acc   = in_valid && !in_stall;
  assign we_left  = in_acc && (req_type == REQ_LOAD_LEFT) && (left_cnt < MAXC);
  assign we_right = in_acc && (req_type == REQ_LOAD_RIGHT) && (right_cnt < MAXC);

  // Hydrophobicity saturates at one and is moved into the internal fraction width.
  assign h_sat   = (hydro_frac > 17'd65536) ? 17'd65536 : hydro_frac;
  assign h_tmp   = (HT'(h_sat) << UP) >> DOWN;
  assign wr_prof = {frag_volume, donor_count, acceptor_count,
                    has_ring, is_aromatic, has_amide, h_tmp[QW-1:0]};

  // Pair issue: rows walk the set being scored, columns the other set.
  logic [CW-1:0] n_row;
  logic [CW-1:0] n_col;
  logic          last_col;
  logic          last_row;
  logic [AW-1:0] left_addr;
  logic [AW-1:0] right_addr;
  logic          issue;

  assign n_row      = dir ? nb : na;
  assign n_col      = dir ? na : nb;
  assign last_col   = (CW'(col_j) + CW'(1)) == n_col;
  assign last_row   = (CW'(row_i) + CW'(1)) == n_row;
  assign left_addr  = dir ? col_j : row_i;
  assign right_addr = dir ? row_i : col_j;
  assign issue      = (state == ST_ISSUE);

  always_ff @(posedge clk) begin
    if (we_left) begin
      left_mem[left_cnt[AW-1:0]] <= wr_prof;
    end
    left_rd <= left_mem[left_addr];
  end

  always_ff @(posedge clk) begin
    if (we_right) begin
      right_mem[right_cnt[AW-1:0]] <= wr_prof;
    end
    right_rd <= right_mem[right_addr];
  end

  // Tag registered once to line up with the registered read data.
  logic rd_valid;
  logic rd_last_col;
  logic rd_last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_last_col <= last_col;
    rd_last_row <= last_row;
  end

  // Feature preparation ahead of the division chain.
  pair_tag_t          ch_tag_in;
  logic [2:0][7:0]    ch_lo;
  logic [2:0][7:0]    ch_hi;
  logic [2:0][7:0]    fa;
  logic [2:0][7:0]    fb;
  logic [QW-1:0]      ha;
  logic [QW-1:0]      hb;
  logic [QW-1:0]      hd;
  logic [QW-1:0]      ch_hyd;

  always_comb begin
    fa[0] = left_rd[QW+26:QW+19];
    fb[0] = right_rd[QW+26:QW+19];
    fa[1] = left_rd[QW+18:QW+11];
    fb[1] = right_rd[QW+18:QW+11];
    fa[2] = left_rd[QW+10:QW+3];
    fb[2] = right_rd[QW+10:QW+3];
    for (int k = 0; k < 3; k++) begin
      ch_lo[k] = (fa[k] < fb[k]) ? fa[k] : fb[k];
      ch_hi[k] = (fa[k] < fb[k]) ? fb[k] : fa[k];
      ch_tag_in.zero[k] = (ch_hi[k] == 8'd0);
    end
    ha = left_rd[QW-1:0];
    hb = right_rd[QW-1:0];
    hd = (ha > hb) ? ha - hb : hb - ha;
    ch_hyd = ONE - hd;
    ch_tag_in.valid     = rd_valid;
    ch_tag_in.last_col  = rd_last_col;
    ch_tag_in.last_row  = rd_last_row;
    ch_tag_in.flag_hits = 2'(left_rd[QW+2] == right_rd[QW+2])
                        + 2'(left_rd[QW+1] == right_rd[QW+1])
                        + 2'(left_rd[QW] == right_rd[QW]);
  end

  pair_tag_t          ch_tag_out;
  logic [2:0][QW-1:0] ch_q;
  logic [QW-1:0]      ch_hyd_out;

  fpss_div_chain #(.QW(QW)) u_chain (
    .clk    (clk),
    .rst    (rst),
    .tag_in (ch_tag_in),
    .lo_in  (ch_lo),
    .hi_in  (ch_hi),
    .hyd_in (ch_hyd),
    .tag_out(ch_tag_out),
    .q_out  (ch_q),
    .hyd_out(ch_hyd_out)
  );

  // Sum of the seven feature scores.
  logic [SN-1:0] feat_sum;
  logic [SN-1:0] sum_r;
  logic          s_valid;
  logic          s_last_col;
  logic          s_last_row;

  always_comb begin
    feat_sum = SN'(ch_hyd_out) + (SN'(ch_tag_out.flag_hits) << FRAC_BITS);
    for (int k = 0; k < 3; k++) begin
      feat_sum = feat_sum + SN'(ch_tag_out.zero[k] ? ONE : ch_q[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= ch_tag_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    sum_r      <= feat_sum;
    s_last_col <= ch_tag_out.last_col;
    s_last_row <= ch_tag_out.last_row;
  end

  // Division by seven as a multiply by its scaled reciprocal.
  logic [SN+MW-1:0] prod_r;
  logic             m_valid;
  logic             m_last_col;
  logic             m_last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= (SN+MW)'(sum_r) * (SN+MW)'(DIV7_M);
    m_last_col <= s_last_col;
    m_last_row <= s_last_row;
  end

  // Best score per row and the running sum of bests.
  logic [SN+MW-1:0] score_w;
  logic [QW-1:0]    score;
  logic [QW-1:0]    best;
  logic [QW-1:0]    best_next;
  logic [SUMW-1:0]  acc_sum;
  logic             acc_done;

  assign score_w   = prod_r >> K7;
  assign score     = score_w[QW-1:0];
  assign best_next = (score > best) ? score : best;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_done <= 1'b0;
      best     <= '0;
      acc_sum  <= '0;
    end else begin
      acc_done <= m_valid && m_last_col && m_last_row;
      if (clr_acc) begin
        best    <= '0;
        acc_sum <= '0;
      end else if (m_valid) begin
        if (m_last_col) begin
          acc_sum <= acc_sum + SUMW'(best_next);
          best    <= '0;
        end else begin
          best <= best_next;
        end
      end
    end
  end

  // Direction average: restoring division of the sum of bests by the row count.
  logic [CW:0]     dt;
  logic            dge;
  logic [CW:0]     dsub;
  logic [CW-1:0]   rem_next;
  logic [SUMW-1:0] quo_next;
  logic [QW:0]     both;
  logic [QW-1:0]   sim_i;
  logic [OT-1:0]   sim_o;

  assign dt       = {div_rem, div_quo[SUMW-1]};
  assign dge      = dt >= {1'b0, n_row};
  assign dsub     = dt - {1'b0, n_row};
  assign rem_next = dge ? dsub[CW-1:0] : dt[CW-1:0];
  assign quo_next = {div_quo[SUMW-2:0], dge};
  assign both     = {1'b0, fw} + {1'b0, quo_next[QW-1:0]};
  assign sim_i    = both[QW:1];
  assign sim_o    = (OT'(sim_i) >> UP) << DOWN;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      dir           <= 1'b0;
      row_i         <= '0;
      col_j         <= '0;
      left_cnt      <= '0;
      right_cnt     <= '0;
      na            <= '0;
      nb            <= '0;
      ovf           <= 1'b0;
      fw            <= '0;
      div_rem       <= '0;
      div_quo       <= '0;
      div_cnt       <= '0;
      clr_acc       <= 1'b0;
      out_valid     <= 1'b0;
      similarity    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      clr_acc <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (req_type == REQ_LOAD_LEFT) begin
              if (we_left) begin
                left_cnt <= left_cnt + CW'(1);
              end else begin
                ovf <= 1'b1;
              end
            end else if (req_type == REQ_LOAD_RIGHT) begin
              if (we_right) begin
                right_cnt <= right_cnt + CW'(1);
              end else begin
                ovf <= 1'b1;
              end
            end else if (req_type == REQ_COMPUTE) begin
              na            <= left_cnt;
              nb            <= right_cnt;
              left_cnt      <= '0;
              right_cnt     <= '0;
              ovf           <= 1'b0;
              overflow_seen <= ovf;
              if ((left_cnt == '0) || (right_cnt == '0)) begin
                similarity <= '0;
                out_valid  <= 1'b1;
              end else begin
                state   <= ST_ISSUE;
                dir     <= 1'b0;
                row_i   <= '0;
                col_j   <= '0;
                clr_acc <= 1'b1;
              end
            end
          end
        end
        ST_ISSUE: begin
          if (last_col) begin
            col_j <= '0;
            if (last_row) begin
              state <= ST_WAIT;
            end else begin
              row_i <= row_i + AW'(1);
            end
          end else begin
            col_j <= col_j + AW'(1);
          end
        end
        ST_WAIT: begin
          if (acc_done) begin
            div_quo <= acc_sum;
            div_rem <= '0;
            div_cnt <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_quo <= quo_next;
          div_rem <= rem_next;
          div_cnt <= div_cnt + DCW'(1);
          if (div_cnt == DCW'(SUMW - 1)) begin
            if (!dir) begin
              fw      <= quo_next[QW-1:0];
              dir     <= 1'b1;
              row_i   <= '0;
              col_j   <= '0;
              clr_acc <= 1'b1;
              state   <= ST_ISSUE;
            end else begin
              similarity <= sim_o[16:0];
              out_valid  <= 1'b1;
              state      <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A result never exceeds one.
  a_sim_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (similarity <= 17'd65536))
    else $error("similarity above one");

  // Set sizes stay within capacity.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (left_cnt <= MAXC) && (right_cnt <= MAXC))
    else $error("set count beyond capacity");

  // Scored pairs only leave the chain while a compute is running.
  a_chain_busy: assert property (@(posedge clk) disable iff (rst)
    ch_tag_out.valid |-> (state != ST_IDLE))
    else $error("pair in flight while idle");

  // The end of a direction is seen only while the sequencer waits for the drain.
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    acc_done |-> (state == ST_WAIT))
    else $error("direction finished outside of wait");

  // A new result is never raised over one still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(similarity))
    else $error("pending result overwritten");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the fragment profile set similarity core.
`timescale 1ns / 1ps

class similarity_scoreboard;
  typedef struct {
    int unsigned vol;
    int unsigned don;
    int unsigned acc;
    bit          ring;
    bit          arom;
    bit          amide;
    longint unsigned hyd;
  } profile_t;

  typedef struct {
    bit [16:0] sim;
    bit        ovf;
  } verdict_t;

  profile_t left_set[$];
  profile_t right_set[$];
  bit       dropped_load;
  verdict_t pending[$];
  int       errors;

  function void clear_all();
    left_set.delete();
    right_set.delete();
    dropped_load = 0;
    pending.delete();
  endfunction

  static function longint unsigned count_match(int unsigned a, int unsigned b);
    int unsigned lo;
    int unsigned hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (hi == 0) return 64'd65536;
    return (longint'(lo) << 16) / hi;
  endfunction

  static function longint unsigned pair_match(profile_t p, profile_t q);
    longint unsigned s;
    longint unsigned d;
    s = count_match(p.vol, q.vol) + count_match(p.don, q.don) + count_match(p.acc, q.acc);
    s += (p.ring == q.ring) ? 65536 : 0;
    s += (p.arom == q.arom) ? 65536 : 0;
    s += (p.amide == q.amide) ? 65536 : 0;
    d = (p.hyd > q.hyd) ? p.hyd - q.hyd : q.hyd - p.hyd;
    s += 65536 - d;
    return s / 7;
  endfunction

  static function longint unsigned mean_best(profile_t a[$], profile_t b[$]);
    longint unsigned sum;
    longint unsigned best;
    longint unsigned s;
    sum = 0;
    foreach (a[i]) begin
      best = 0;
      foreach (b[j]) begin
        s = pair_match(a[i], b[j]);
        if (s > best) best = s;
      end
      sum += best;
    end
    return sum / a.size();
  endfunction

  // Notes one accepted request and updates the mirrored sets.
  function void note_request(bit [1:0] req, bit [7:0] vol, bit [7:0] don, bit [7:0] acc,
                             bit ring, bit arom, bit amide, bit [16:0] hyd);
    profile_t p;
    verdict_t v;
    p.vol = 32'(vol);
    p.don = 32'(don);
    p.acc = 32'(acc);
    p.ring = ring;
    p.arom = arom;
    p.amide = amide;
    p.hyd = (hyd > 17'd65536) ? 64'd65536 : 64'(hyd);
    case (req)
      fpss_pkg::REQ_LOAD_LEFT: begin
        if (left_set.size() < 64) left_set = {left_set, p};
        else dropped_load = 1;
      end
      fpss_pkg::REQ_LOAD_RIGHT: begin
        if (right_set.size() < 64) right_set = {right_set, p};
        else dropped_load = 1;
      end
      fpss_pkg::REQ_COMPUTE: begin
        v.sim = '0;
        if (left_set.size() > 0 && right_set.size() > 0)
          v.sim = 17'((mean_best(left_set, right_set) + mean_best(right_set, left_set)) >> 1);
        v.ovf = dropped_load;
        pending = {pending, v};
        left_set.delete();
        right_set.delete();
        dropped_load = 0;
      end
      default: ;
    endcase
  endfunction

  task report(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  task check_result(bit [16:0] sim, bit ovf);
    verdict_t v;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result sim=%0d ovf=%0d", sim, ovf));
      return;
    end
    v = pending.pop_front();
    if (sim !== v.sim) report($sformatf("similarity %0d, want %0d", sim, v.sim));
    if (ovf !== v.ovf) report($sformatf("overflow_seen %0d, want %0d", ovf, v.ovf));
  endtask
endclass

module testbench;
  import fpss_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [7:0]  frag_volume = '0;
  logic [7:0]  donor_count = '0;
  logic [7:0]  acceptor_count = '0;
  logic        has_ring = 0;
  logic        is_aromatic = 0;
  logic        has_amide = 0;
  logic [16:0] hydro_frac = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [16:0] similarity;
  logic        overflow_seen;

  similarity_scoreboard board = new();

  // Idle percentages for the sender and the receiver; changed per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // When set, the receiver holds off for a long stretch regardless of the percentage.
  bit          hold_off = 0;
  longint unsigned cycle_count = 0;

  fragment_profile_set_similarity_core u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Timeout guard. The run holds one full 64x64 compute, so this bound is many times the
  // slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3_000_000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: every output transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(similarity, overflow_seen);
    if (rst) out_stall <= 0;
    else if (hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Offers one request and waits until the block takes it. Idle cycles are inserted
  // before the offer; valid stays high across back-to-back transactions.
  task automatic send_request(bit [1:0] req, bit [7:0] vol, bit [7:0] don, bit [7:0] acc,
                              bit ring, bit arom, bit amide, bit [16:0] hyd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    req_type <= req;
    frag_volume <= vol;
    donor_count <= don;
    acceptor_count <= acc;
    has_ring <= ring;
    is_aromatic <= arom;
    has_amide <= amide;
    hydro_frac <= hyd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(req, vol, don, acc, ring, arom, amide, hyd);
  endtask

  task automatic send_profile(bit [1:0] side);
    bit [16:0] hyd;
    case ($urandom_range(3))
      0: hyd = 17'd65536;
      1: hyd = 17'($urandom_range(17'h1FFFF, 17'd65537));
      default: hyd = 17'($urandom_range(65535));
    endcase
    // Small counts make equal and zero counts common, wide ones reach the top bits.
    send_request(side, 8'($urandom_range(1) ? $urandom_range(4) : $urandom_range(255)),
                 8'($urandom_range(1) ? $urandom_range(3) : $urandom_range(255)),
                 8'($urandom_range(1) ? $urandom_range(3) : $urandom_range(255)),
                 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)), hyd);
  endtask

  task automatic send_compute();
    send_request(REQ_COMPUTE, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                 1'($urandom), 1'($urandom), 17'($urandom));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // A well-formed burst: a few loads on each side, sometimes none, an occasional ignored request, then a compute.
  task automatic random_set();
    int nl;
    int nr;
    nl = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
    nr = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
    while (nl > 0 || nr > 0) begin
      if (nr == 0 || (nl > 0 && $urandom_range(1))) begin
        send_profile(REQ_LOAD_LEFT);
        nl--;
      end else begin
        send_profile(REQ_LOAD_RIGHT);
        nr--;
      end
    end
    if ($urandom_range(19) == 0) send_request(REQ_IGNORED, 8'($urandom), 8'($urandom),
                                              8'($urandom), 1'($urandom), 1'($urandom),
                                              1'($urandom), 17'($urandom));
    send_compute();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty sets, one empty side, identical extremes, opposite extremes, one left against two right.
    send_compute();
    send_request(REQ_LOAD_LEFT, 8'd0, 8'd0, 8'd0, 0, 0, 0, 17'd0);
    send_compute();
    send_request(REQ_LOAD_RIGHT, 8'd255, 8'd255, 8'd255, 1, 1, 1, 17'd65536);
    send_compute();
    send_request(REQ_LOAD_LEFT, 8'd0, 8'd0, 8'd0, 0, 0, 0, 17'd0);
    send_request(REQ_LOAD_RIGHT, 8'd0, 8'd0, 8'd0, 0, 0, 0, 17'd0);
    send_compute();
    send_request(REQ_LOAD_LEFT, 8'd0, 8'd0, 8'd0, 0, 0, 0, 17'd0);
    send_request(REQ_LOAD_RIGHT, 8'd255, 8'd255, 8'd255, 1, 1, 1, 17'h1FFFF);
    send_request(REQ_IGNORED, 8'd1, 8'd1, 8'd1, 1, 1, 1, 17'd1);
    send_compute();
    send_request(REQ_LOAD_LEFT, 8'd1, 8'd255, 8'd128, 1, 0, 1, 17'd65535);
    send_request(REQ_LOAD_RIGHT, 8'd255, 8'd1, 8'd127, 0, 1, 0, 17'd65537);
    send_request(REQ_LOAD_RIGHT, 8'd2, 8'd200, 8'd128, 1, 0, 1, 17'd32768);
    send_compute();

    // Full sets: 65 loads per side, the last of each dropped and flagged.
    repeat (65) send_profile(REQ_LOAD_LEFT);
    repeat (65) send_profile(REQ_LOAD_RIGHT);
    send_compute();
    drain();

    // Overflow on the left only, with a small right set.
    repeat (66) send_profile(REQ_LOAD_LEFT);
    send_profile(REQ_LOAD_RIGHT);
    send_compute();
    drain();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 61 : (phase == 3) ? 25 : 0;
      recv_stall_pct = (phase == 2) ? 61 : (phase == 3) ? 25 : 0;
      repeat (15) random_set();
      drain();
    end

    // Pressure: the receiver holds off while results pile up, so the block
    // stalls its input behind the pending result.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      repeat (12) random_set();
    join
    drain();

    // Wait out any trailing pipeline activity before ending.
    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
